// ===== rtl/sfla_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg
// shared types, constants and helpers of the free list allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int unsigned HeapWords  = 65536;
  localparam int unsigned AddrW      = $clog2(HeapWords);
  localparam int unsigned WordsW     = AddrW + 1;
  localparam int unsigned ExactLists = 16;
  localparam int unsigned MinBlock   = 2;
  localparam int unsigned NumLists   = ExactLists + 1;
  localparam int unsigned ListW      = $clog2(NumLists);

  localparam logic [WordsW-1:0] NULL_LINK = WordsW'(HeapWords);
  localparam logic [ListW-1:0]  MISC_IDX  = ListW'(ExactLists);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  typedef struct packed {
    logic              func;
    logic [WordsW-1:0] words;
    logic [AddrW-1:0]  addr;
    logic              under;
    logic              exact;
    logic [ListW-1:0]  idx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic [ListW-1:0] list_index(input logic [WordsW-1:0] size);
    logic [ListW-1:0] r;
    if (size < WordsW'(ExactLists + MinBlock)) begin
      r = ListW'(size - WordsW'(MinBlock));
    end else begin
      r = MISC_IDX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sfla_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_front
// request intake: classifies each transfer and holds it in a two-entry queue
// ----------------------------------------------------------------------------
module sfla_front import sfla_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              func_i,
  input  wire logic [WordsW-1:0] block_words_i,
  input  wire logic [AddrW-1:0]  block_addr_i,
  output queue_head_t            head_o,
  input  wire logic              pop_i
);

  item_t       mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       cls;

  always_comb begin
    cls.func  = func_i;
    cls.words = block_words_i;
    cls.addr  = block_addr_i;
    cls.under = block_words_i < WordsW'(MinBlock);
    cls.exact = block_words_i < WordsW'(ExactLists + MinBlock);
    cls.idx   = list_index(block_words_i);
  end

  assign in_stall_o = cnt_q == 2'd2;
  assign push       = in_valid_i && !in_stall_o;
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfla_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_back
// list engine: exact pops, bump, misc first-fit walk, split and release
// ----------------------------------------------------------------------------
module sfla_back import sfla_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WordsW-1:0] cfg_data_i,
  input  queue_head_t            head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [AddrW-1:0]       granted_addr_o,
  output logic [WordsW-1:0]      words_used_o,
  output logic [WordsW-1:0]      top_offset_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_WRD   = 5'b00100,
    S_WCHK  = 5'b01000,
    S_SPLIT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [WordsW-1:0]   heads_q [NumLists];
  logic [WordsW-1:0]   heads_d [NumLists];
  logic [WordsW-1:0]   top_q, top_d, used_q, used_d, limit_q;
  logic [WordsW-1:0]   b_q, b_d, prev_q, prev_d, visits_q, visits_d;
  logic [WordsW-1:0]   size_q, size_d, tsize_q, tsize_d;
  logic [AddrW-1:0]    taddr_q, taddr_d;
  logic                small_q, small_d;
  logic [ListW-1:0]    idx_q, idx_d;

  logic [WordsW-1:0]   link_mem [HeapWords];
  logic [WordsW-1:0]   size_mem [HeapWords];
  logic [WordsW-1:0]   link_rd_q, size_rd_q;
  logic [AddrW-1:0]    rd_addr;
  logic                lwe, swe;
  logic [AddrW-1:0]    lw_addr, sw_addr;
  logic [WordsW-1:0]   lw_data, sw_data;

  logic                fin, ok;
  logic [1:0]          fin_status;
  logic [AddrW-1:0]    fin_addr;
  logic [WordsW-1:0]   lim, cur_size;
  logic                bump_ok, fit;
  logic [WordsW:0]     bump_sum, used_sum;
  logic [ListW-1:0]    tidx;
  item_t               it;

  assign it  = head_i.item;
  assign lim = (limit_q > WordsW'(HeapWords)) ? WordsW'(HeapWords) : limit_q;
  assign cur_size = (state_q == S_IDLE) ? it.words : size_q;
  assign bump_sum = {1'b0, top_q} + {1'b0, cur_size};
  assign bump_ok  = bump_sum <= {1'b0, lim};
  assign used_sum = {1'b0, used_q} + {1'b0, cur_size};
  assign fit  = (size_rd_q == size_q) ||
                ({1'b0, size_rd_q} >= ({1'b0, size_q} + (WordsW+1)'(MinBlock)));
  assign tidx = list_index(tsize_q);

  always_comb begin
    state_d    = state_q;
    heads_d    = heads_q;
    top_d      = top_q;
    used_d     = used_q;
    b_d        = b_q;
    prev_d     = prev_q;
    visits_d   = visits_q;
    size_d     = size_q;
    small_d    = small_q;
    idx_d      = idx_q;
    taddr_d    = taddr_q;
    tsize_d    = tsize_q;
    rd_addr    = b_q[AddrW-1:0];
    lwe        = 1'b0;
    swe        = 1'b0;
    lw_addr    = it.addr;
    lw_data    = heads_q[it.idx];
    sw_addr    = it.addr;
    sw_data    = it.words;
    pop_o      = 1'b0;
    fin        = 1'b0;
    ok         = 1'b0;
    fin_status = ST_OK;
    fin_addr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid && !out_valid_o) begin
          pop_o   = 1'b1;
          size_d  = it.words;
          small_d = it.exact;
          idx_d   = it.idx;
          if (it.under) begin
            fin        = 1'b1;
            fin_status = ST_UNDER;
          end else if (it.func == FUNC_FREE) begin
            lwe = 1'b1;
            swe = 1'b1;
            heads_d[it.idx] = {1'b0, it.addr};
            used_d = (used_q > it.words) ? used_q - it.words : '0;
            fin = 1'b1;
          end else if (it.exact && !heads_q[it.idx][AddrW]) begin
            rd_addr = heads_q[it.idx][AddrW-1:0];
            b_d     = heads_q[it.idx];
            state_d = S_POP;
          end else if (it.exact && bump_ok) begin
            top_d    = bump_sum[WordsW-1:0];
            fin_addr = top_q[AddrW-1:0];
            ok       = 1'b1;
          end else begin
            b_d      = heads_q[MISC_IDX];
            prev_d   = NULL_LINK;
            visits_d = '0;
            state_d  = S_WRD;
          end
        end
      end
      S_POP: begin
        heads_d[idx_q] = link_rd_q;
        fin_addr = b_q[AddrW-1:0];
        ok       = 1'b1;
        state_d  = S_IDLE;
      end
      S_WRD: begin
        if (b_q[AddrW] || visits_q[AddrW]) begin
          state_d = S_IDLE;
          if (!small_q && bump_ok) begin
            top_d    = bump_sum[WordsW-1:0];
            fin_addr = top_q[AddrW-1:0];
            ok       = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_status = ST_NOSPACE;
          end
        end else begin
          rd_addr = b_q[AddrW-1:0];
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (fit) begin
          if (prev_q[AddrW]) begin
            heads_d[MISC_IDX] = link_rd_q;
          end else begin
            lwe     = 1'b1;
            lw_addr = prev_q[AddrW-1:0];
            lw_data = link_rd_q;
          end
          if (size_rd_q != size_q) begin
            taddr_d = b_q[AddrW-1:0] + size_q[AddrW-1:0];
            tsize_d = size_rd_q - size_q;
            state_d = S_SPLIT;
          end else begin
            fin_addr = b_q[AddrW-1:0];
            ok       = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          prev_d   = b_q;
          b_d      = link_rd_q;
          visits_d = visits_q + WordsW'(1);
          state_d  = S_WRD;
        end
      end
      S_SPLIT: begin
        lwe     = 1'b1;
        swe     = 1'b1;
        lw_addr = taddr_q;
        lw_data = heads_q[tidx];
        sw_addr = taddr_q;
        sw_data = tsize_q;
        heads_d[tidx] = {1'b0, taddr_q};
        fin_addr = b_q[AddrW-1:0];
        ok       = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (ok) begin
      fin    = 1'b1;
      used_d = used_sum[WordsW] ? '1 : used_sum[WordsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (swe) begin
      size_mem[sw_addr] <= sw_data;
    end
    link_rd_q <= link_mem[rd_addr];
    size_rd_q <= size_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    b_q      <= b_d;
    prev_q   <= prev_d;
    visits_q <= visits_d;
    size_q   <= size_d;
    small_q  <= small_d;
    idx_q    <= idx_d;
    taddr_q  <= taddr_d;
    tsize_q  <= tsize_d;
    if (fin) begin
      status_o       <= fin_status;
      granted_addr_o <= fin_addr;
      words_used_o   <= used_d;
      top_offset_o   <= top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heads_q     <= '{default: NULL_LINK};
      top_q       <= '0;
      used_q      <= '0;
      limit_q     <= WordsW'(HeapWords);
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      heads_q <= heads_d;
      top_q   <= top_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (fin) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/segregated_free_list_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_unit
// word-addressed heap allocator with exact-size lists, misc list and bump top
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with func_i, block_words_i and
// block_addr_i; a transfer enters a two-entry queue after classification
// output channel: out_valid_o / out_stall_i with one result per request:
// status_o, granted_addr_o, words_used_o, top_offset_o
// cfg_we_i / cfg_data_i write the heap limit; user must write only while the unit is idle (not enforced)
// one request is in the list engine at a time; from queue head to result:
// undersized, release and an exact-list miss served by bump end in idle,
// an exact-list pop goes through the pop state, a misc walk reads and then
// checks each block visited, a split adds the split state, and with no fit
// the walk ends in the read state
// the misc walk is bound by the single read port of the link/size memories
// a result stays on the output register while out_stall_i is high; the
// engine takes the next request only once the output register is free
// reset empties all lists, clears top and used count, sets the limit to
// 65536; link and size memories are not cleared, every entry is written
// before it is read
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_unit import sfla_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WordsW-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              func_i,
  input  wire logic [WordsW-1:0] block_words_i,
  input  wire logic [AddrW-1:0]  block_addr_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [AddrW-1:0]       granted_addr_o,
  output logic [WordsW-1:0]      words_used_o,
  output logic [WordsW-1:0]      top_offset_o
);

  queue_head_t head;
  logic        pop;

  sfla_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .block_words_i (block_words_i),
    .block_addr_i  (block_addr_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  sfla_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_addr_o (granted_addr_o),
    .words_used_o   (words_used_o),
    .top_offset_o   (top_offset_o)
  );

  a_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_addr_o == '0)
    else $error("grant address set on failed request");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> top_offset_o <= WordsW'(HeapWords))
    else $error("top beyond heap");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("queue pop while empty");

endmodule
`default_nettype wire
